>>> rtl/smi_pkg.sv
// Shared types and constants of the two-axis stepper move interlock.
package smi_pkg;

  localparam int unsigned COUNT_WIDTH_DEF    = 24;
  localparam int unsigned POSITION_WIDTH_DEF = 32;
  localparam int unsigned CFG_WIDTH          = 24;
  localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = '1;

  typedef enum logic [3:0] {
    K_PULSE    = 4'd0,
    K_RUN      = 4'd1,
    K_MOVE     = 4'd2,
    K_DIR      = 4'd3,
    K_HOLD     = 4'd4,
    K_POSITION = 4'd5,
    K_ESCAPE   = 4'd6,
    K_PHOTO    = 4'd7,
    K_STOP_ALL = 4'd8
  } smi_kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_BUSY   = 2'd2
  } smi_status_e;

  typedef enum logic {
    CFG_X_LIMIT = 1'b0,
    CFG_Z_LIMIT = 1'b1
  } smi_cfg_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic               axis_index;
    logic               flag;
    logic [23:0]        move_count;
    logic signed [31:0] position_value;
    logic               photo_blocked;
  } smi_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               run_x;
    logic               run_z;
    logic               dir_x;
    logic               dir_z;
    logic               hold_x;
    logic               hold_z;
    logic signed [31:0] position_out;
    logic [23:0]        remaining_out;
    logic [23:0]        completed_out;
    logic               move_active_out;
    logic               limit_owned;
  } smi_out_t;

endpackage

>>> rtl/two_axis_stepper_move_interlock.sv
// Top level of the two-axis stepper move interlock: input stage and core.
// A command transfer loads the input register; when the core takes the command, the
// result register loads with the state update. Throughput: one command per cycle
// unless the output stalls; the single-pass state update sets this figure.
// Reset: asynchronous; clears the axis state except that Z starts with hold policy,
// holding and has-moved set, clears the recorded limit and both stages, and sets both
// travel limits to their largest value. No clearing pass is needed.
module two_axis_stepper_move_interlock #(
  parameter int unsigned COUNT_WIDTH    = smi_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = smi_pkg::POSITION_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [smi_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  smi_pkg::smi_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output smi_pkg::smi_out_t             out_data_o
);
  import smi_pkg::*;

  logic    take;
  logic    s_valid;
  smi_in_t s_data;

  smi_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (s_valid),
    .data_o     (s_data)
  );

  smi_core #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (s_valid),
    .data_i      (s_data),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/smi_in_reg.sv
// Input register stage that holds one command transfer until the core takes it.
module smi_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  smi_pkg::smi_in_t in_data_i,
  input  logic           take_i,
  output logic           valid_o,
  output smi_pkg::smi_in_t data_o
);
  import smi_pkg::*;

  logic    valid_q, valid_d;
  smi_in_t data_q;
  logic    accept;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/smi_core.sv
// Axis state, interlock rules, travel limit registers and the result register.
module smi_core #(
  parameter int unsigned COUNT_WIDTH    = smi_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = smi_pkg::POSITION_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [smi_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                          valid_i,
  input  smi_pkg::smi_in_t              data_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output smi_pkg::smi_out_t             out_data_o
);
  import smi_pkg::*;

  localparam int unsigned C = COUNT_WIDTH;
  localparam int unsigned P = POSITION_WIDTH;

  logic [CFG_WIDTH-1:0] xlim_q, zlim_q;

  logic [1:0] run_q, run_d;
  logic [1:0] dir_q, dir_d;
  logic [1:0] hpol_q, hpol_d;
  logic [1:0] moved_q, moved_d;
  logic [1:0] hold_q, hold_d;
  logic [1:0] act_q, act_d;
  logic [C-1:0] rem_q [2];
  logic [C-1:0] rem_d [2];
  logic [C-1:0] cmp_q [2];
  logic [C-1:0] cmp_d [2];
  logic [P-1:0] pos_q [2];
  logic [P-1:0] pos_d [2];
  logic lrec_q, lrec_d;
  logic lax_q, lax_d;
  logic ldir_q, ldir_d;

  logic     out_valid_q;
  smi_out_t out_q, res;

  function automatic logic may_start(logic [1:0] run, logic [1:0] dir, logic a,
                                     logic photo, logic lrec, logic lax, logic ldir);
    logic ok;
    if (run[~a]) begin
      ok = 1'b0;
    end else if (!photo) begin
      ok = 1'b1;
    end else begin
      ok = lrec && (a == lax) && (dir[a] != ldir);
    end
    return ok;
  endfunction

  assign take_o = valid_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    logic        a;
    logic        photo;
    logic        sa;
    logic [31:0] cnt_ext;
    logic [C-1:0] cnt;
    logic [31:0] lim_ext;
    logic [31:0] rem_ext;
    logic [31:0] cmp_ext;
    logic [1:0]  status;

    a       = data_i.axis_index;
    photo   = data_i.photo_blocked;
    sa      = 1'b0;
    cnt_ext = 32'(data_i.move_count);
    cnt     = cnt_ext[C-1:0];
    lim_ext = 32'(a ? zlim_q : xlim_q);
    status  = ST_OK;

    run_d   = run_q;
    dir_d   = dir_q;
    hpol_d  = hpol_q;
    moved_d = moved_q;
    hold_d  = hold_q;
    act_d   = act_q;
    rem_d   = rem_q;
    cmp_d   = cmp_q;
    pos_d   = pos_q;
    lrec_d  = lrec_q;
    lax_d   = lax_q;
    ldir_d  = ldir_q;

    unique case (data_i.kind)
      K_PULSE: begin
        if (run_q[a]) begin
          pos_d[a] = dir_q[a] ? pos_q[a] - P'(1) : pos_q[a] + P'(1);
          if (act_q[a] && rem_q[a] != '0) begin
            rem_d[a] = rem_q[a] - C'(1);
            cmp_d[a] = cmp_q[a] + C'(1);
            if (rem_d[a] == '0) begin
              act_d[a]  = 1'b0;
              run_d[a]  = 1'b0;
              hold_d[a] = hpol_q[a] & moved_q[a];
            end
          end
        end
      end
      K_RUN: begin
        act_d[a] = 1'b0;
        rem_d[a] = '0;
        if (data_i.flag &&
            may_start(run_q, dir_q, a, photo, lrec_q, lax_q, ldir_q)) begin
          run_d[a]   = 1'b1;
          moved_d[a] = 1'b1;
          hold_d[a]  = 1'b0;
        end else begin
          if (data_i.flag) begin
            status = ST_BUSY;
          end
          run_d[a]  = 1'b0;
          hold_d[a] = hpol_q[a] & moved_q[a];
        end
      end
      K_MOVE: begin
        if (cnt == '0 || 32'(cnt) > lim_ext) begin
          status = ST_REJECT;
        end else begin
          act_d[a]  = 1'b0;
          rem_d[a]  = '0;
          run_d[a]  = 1'b0;
          hold_d[a] = hpol_q[a] & moved_q[a];
          dir_d[a]  = data_i.flag;
          if (!may_start(run_d, dir_d, a, photo, lrec_q, lax_q, ldir_q)) begin
            status = ST_BUSY;
          end else begin
            cmp_d[a]   = '0;
            rem_d[a]   = cnt;
            act_d[a]   = 1'b1;
            run_d[a]   = 1'b1;
            moved_d[a] = 1'b1;
            hold_d[a]  = 1'b0;
          end
        end
      end
      K_DIR: begin
        dir_d[a] = data_i.flag;
      end
      K_HOLD: begin
        hpol_d[a] = data_i.flag;
        if (!run_q[a]) begin
          hold_d[a] = data_i.flag;
          if (data_i.flag) begin
            moved_d[a] = 1'b1;
          end
        end
      end
      K_POSITION: begin
        if (run_q[a]) begin
          status = ST_REJECT;
        end else begin
          pos_d[a] = data_i.position_value[P-1:0];
        end
      end
      K_ESCAPE: begin
        if (!photo || run_q[0] || run_q[1]) begin
          status = ST_REJECT;
        end else begin
          lax_d  = a;
          ldir_d = data_i.flag;
          lrec_d = 1'b1;
        end
      end
      K_PHOTO: begin
        if (!photo) begin
          lrec_d = 1'b0;
        end else if (!lrec_q) begin
          if (run_q[0] || run_q[1]) begin
            sa         = ~run_q[0];
            lax_d      = sa;
            ldir_d     = dir_q[sa];
            lrec_d     = 1'b1;
            act_d[sa]  = 1'b0;
            rem_d[sa]  = '0;
            run_d[sa]  = 1'b0;
            hold_d[sa] = hpol_q[sa] & moved_q[sa];
          end
        end else if (run_q[lax_q] && dir_q[lax_q] == ldir_q) begin
          act_d[lax_q]  = 1'b0;
          rem_d[lax_q]  = '0;
          run_d[lax_q]  = 1'b0;
          hold_d[lax_q] = hpol_q[lax_q] & moved_q[lax_q];
        end
      end
      K_STOP_ALL: begin
        run_d   = '0;
        hold_d  = '0;
        moved_d = '0;
        act_d   = '0;
        rem_d   = '{default: '0};
      end
      default: begin
        status = ST_REJECT;
      end
    endcase

    rem_ext = 32'(rem_d[a]);
    cmp_ext = 32'(cmp_d[a]);

    res.status          = status;
    res.run_x           = run_d[0];
    res.run_z           = run_d[1];
    res.dir_x           = dir_d[0];
    res.dir_z           = dir_d[1];
    res.hold_x          = hold_d[0];
    res.hold_z          = hold_d[1];
    res.position_out    = 32'(signed'(pos_d[a]));
    res.remaining_out   = rem_ext[23:0];
    res.completed_out   = cmp_ext[23:0];
    res.move_active_out = act_d[a];
    res.limit_owned     = photo & lrec_d & (lax_d == a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlim_q      <= LIMIT_RESET;
      zlim_q      <= LIMIT_RESET;
      run_q       <= 2'b00;
      dir_q       <= 2'b00;
      hpol_q      <= 2'b10;
      moved_q     <= 2'b10;
      hold_q      <= 2'b10;
      act_q       <= 2'b00;
      rem_q       <= '{default: '0};
      cmp_q       <= '{default: '0};
      pos_q       <= '{default: '0};
      lrec_q      <= 1'b0;
      lax_q       <= 1'b0;
      ldir_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_X_LIMIT) begin
          xlim_q <= cfg_wdata_i;
        end else begin
          zlim_q <= cfg_wdata_i;
        end
      end
      if (take_o) begin
        run_q       <= run_d;
        dir_q       <= dir_d;
        hpol_q      <= hpol_d;
        moved_q     <= moved_d;
        hold_q      <= hold_d;
        act_q       <= act_d;
        rem_q       <= rem_d;
        cmp_q       <= cmp_d;
        pos_q       <= pos_d;
        lrec_q      <= lrec_d;
        lax_q       <= lax_d;
        ldir_q      <= ldir_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_runner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q[0] && run_q[1]))
    else $error("both axes running");

  a_move_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((act_q[0] -> run_q[0]) && (act_q[1] -> run_q[1])))
    else $error("counted move active on a stopped axis");

  a_move_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((act_q[0] -> rem_q[0] != '0) && (act_q[1] -> rem_q[1] != '0)))
    else $error("counted move active with no pulses left");

  a_hold_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((hold_q & run_q) == 2'b00))
    else $error("axis holding while running");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !take_o) |=> !out_valid_q)
    else $error("result repeated after transfer");

endmodule

>>> tb/two_axis_stepper_move_interlock_tb.sv
// Self-checking testbench for the two-axis stepper move interlock.
`timescale 1ns / 100ps

module two_axis_stepper_move_interlock_tb;
  import smi_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [3:0]  K_BAD_LOW  = 4'd9;
  localparam logic [3:0]  K_BAD_TOP  = 4'd15;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic                 cfg_index_i = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  smi_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  smi_out_t             out_data_o;

  two_axis_stepper_move_interlock u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Axis state of the predictor, bit 0 is X and bit 1 is Z.
  logic [1:0]  run_q      = 2'b00;
  logic [1:0]  dir_q      = 2'b00;
  logic [1:0]  hold_pol_q = 2'b10;
  logic [1:0]  moved_q    = 2'b10;
  logic [1:0]  hold_q     = 2'b10;
  logic [1:0]  move_q     = 2'b00;
  logic [23:0] rem_q [2]  = '{24'd0, 24'd0};
  logic [23:0] done_q [2] = '{24'd0, 24'd0};
  logic [31:0] pos_q [2]  = '{32'd0, 32'd0};
  logic        lim_rec_q  = 1'b0;
  logic        lim_axis_q = 1'b0;
  logic        lim_dir_q  = 1'b0;
  logic [23:0] x_limit    = LIMIT_RESET;
  logic [23:0] z_limit    = LIMIT_RESET;

  smi_out_t expected_q [$];

  logic        beam          = 1'b0;
  logic        no_gaps       = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned hold_off_left = 0;
  int unsigned sent_cnt      = 0;
  int unsigned checked_cnt   = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned busy_cnt      = 0;
  int unsigned moves_done    = 0;
  int unsigned cfg_writes    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic can_start(logic ax, logic ph);
    if (run_q[~ax]) return 1'b0;
    if (!ph) return 1'b1;
    return lim_rec_q && (ax == lim_axis_q) && (dir_q[ax] != lim_dir_q);
  endfunction

  function automatic void park(logic ax);
    run_q[ax]  = 1'b0;
    hold_q[ax] = hold_pol_q[ax] && moved_q[ax];
  endfunction

  function automatic void drop_move(logic ax);
    move_q[ax] = 1'b0;
    rem_q[ax]  = 24'd0;
  endfunction

  // Returns 1 when a requested start is refused by the interlock.
  function automatic logic apply_run(logic ax, logic en, logic ph);
    logic refused;
    refused = 1'b0;
    drop_move(ax);
    if (en && !can_start(ax, ph)) begin
      en = 1'b0;
      refused = 1'b1;
    end
    if (en) begin
      run_q[ax]   = 1'b1;
      moved_q[ax] = 1'b1;
      hold_q[ax]  = 1'b0;
    end else begin
      park(ax);
    end
    return refused;
  endfunction

  function automatic smi_out_t predict_cmd(smi_in_t c);
    smi_out_t r;
    logic     ax;
    logic     ph;
    r = '0;
    ax = c.axis_index;
    ph = c.photo_blocked;
    r.status = ST_OK;
    case (c.kind)
      K_PULSE: begin
        if (run_q[ax]) begin
          pos_q[ax] = pos_q[ax] + (dir_q[ax] ? 32'hFFFF_FFFF : 32'd1);
          if (move_q[ax] && rem_q[ax] != 24'd0) begin
            rem_q[ax]  = rem_q[ax] - 24'd1;
            done_q[ax] = done_q[ax] + 24'd1;
            if (rem_q[ax] == 24'd0) begin
              move_q[ax] = 1'b0;
              park(ax);
              moves_done++;
            end
          end
        end
      end
      K_RUN: begin
        if (apply_run(ax, c.flag, ph)) r.status = ST_BUSY;
      end
      K_MOVE: begin
        if (c.move_count == 24'd0 || c.move_count > (ax ? z_limit : x_limit)) begin
          r.status = ST_REJECT;
        end else begin
          void'(apply_run(ax, 1'b0, ph));
          dir_q[ax] = c.flag;
          if (!can_start(ax, ph)) begin
            r.status = ST_BUSY;
          end else begin
            done_q[ax]  = 24'd0;
            rem_q[ax]   = c.move_count;
            move_q[ax]  = 1'b1;
            run_q[ax]   = 1'b1;
            moved_q[ax] = 1'b1;
            hold_q[ax]  = 1'b0;
          end
        end
      end
      K_DIR: dir_q[ax] = c.flag;
      K_HOLD: begin
        hold_pol_q[ax] = c.flag;
        if (!run_q[ax]) begin
          hold_q[ax] = c.flag;
          if (c.flag) moved_q[ax] = 1'b1;
        end
      end
      K_POSITION: begin
        if (run_q[ax]) r.status = ST_REJECT;
        else pos_q[ax] = c.position_value;
      end
      K_ESCAPE: begin
        if (!ph || run_q != 2'b00) begin
          r.status = ST_REJECT;
        end else begin
          lim_axis_q = ax;
          lim_dir_q  = c.flag;
          lim_rec_q  = 1'b1;
        end
      end
      K_PHOTO: begin
        if (!ph) begin
          lim_rec_q = 1'b0;
        end else if (!lim_rec_q) begin
          if (run_q != 2'b00) begin
            // X takes precedence when both run.
            lim_axis_q = ~run_q[0];
            lim_dir_q  = dir_q[lim_axis_q];
            lim_rec_q  = 1'b1;
            void'(apply_run(lim_axis_q, 1'b0, ph));
          end
        end else if (run_q[lim_axis_q] && dir_q[lim_axis_q] == lim_dir_q) begin
          void'(apply_run(lim_axis_q, 1'b0, ph));
        end
      end
      K_STOP_ALL: begin
        run_q   = 2'b00;
        hold_q  = 2'b00;
        moved_q = 2'b00;
        drop_move(1'b0);
        drop_move(1'b1);
      end
      default: r.status = ST_REJECT;
    endcase
    if (r.status == ST_BUSY) busy_cnt++;
    r.run_x           = run_q[0];
    r.run_z           = run_q[1];
    r.dir_x           = dir_q[0];
    r.dir_z           = dir_q[1];
    r.hold_x          = hold_q[0];
    r.hold_z          = hold_q[1];
    r.position_out    = pos_q[ax];
    r.remaining_out   = rem_q[ax];
    r.completed_out   = done_q[ax];
    r.move_active_out = move_q[ax];
    r.limit_owned     = ph && lim_rec_q && (lim_axis_q == ax);
    return r;
  endfunction

  function automatic smi_in_t build_cmd(logic [3:0] k, logic ax, logic fl,
                                        logic [23:0] cnt, logic [31:0] pv, logic ph);
    smi_in_t c;
    c.kind           = k;
    c.axis_index     = ax;
    c.flag           = fl;
    c.move_count     = cnt;
    c.position_value = pv;
    c.photo_blocked  = ph;
    return c;
  endfunction

  // Mostly well-formed traffic: pulses follow the running axis and the beam
  // stays in one state for stretches so that limit sequences can play out.
  function automatic smi_in_t random_cmd();
    smi_in_t     c;
    int unsigned roll;
    logic [23:0] lim;
    if (beam ? ($urandom_range(0, 99) < 12) : ($urandom_range(0, 99) < 4)) beam = ~beam;
    c = build_cmd(K_PULSE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  24'($urandom), $urandom, beam);
    roll = $urandom_range(0, 99);
    if (roll < 38) begin
      if (run_q != 2'b00 && $urandom_range(0, 9) < 8) c.axis_index = ~run_q[0];
    end else if (roll < 50) begin
      c.kind = K_RUN;
      c.flag = ($urandom_range(0, 3) != 0);
    end else if (roll < 62) begin
      c.kind = K_MOVE;
      lim = c.axis_index ? z_limit : x_limit;
      case ($urandom_range(0, 9))
        0: c.move_count = 24'd0;
        1: ;
        2: c.move_count = lim;
        3: c.move_count = lim + 24'd1;
        default: c.move_count = 24'($urandom_range(1, 8));
      endcase
    end else if (roll < 69) begin
      c.kind = K_DIR;
    end else if (roll < 74) begin
      c.kind = K_HOLD;
    end else if (roll < 79) begin
      c.kind = K_POSITION;
    end else if (roll < 85) begin
      c.kind = K_ESCAPE;
    end else if (roll < 95) begin
      c.kind = K_PHOTO;
    end else if (roll < 98) begin
      c.kind = K_STOP_ALL;
    end else begin
      c.kind = 4'($urandom_range(K_BAD_LOW, K_BAD_TOP));
    end
    return c;
  endfunction

  task automatic send_cmd(smi_in_t c);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_cmd(c));
    sent_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(smi_cfg_e idx, logic [23:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_X_LIMIT) x_limit = val;
    else z_limit = val;
    cfg_writes++;
  endtask

  task automatic test_directed();
    send_cmd(build_cmd(K_PULSE, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_BAD_TOP, 1'b1, 1'b1, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1));
    send_cmd(build_cmd(K_BAD_LOW, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_POSITION, 1'b0, 1'b0, 24'd0, 32'h7FFF_FFFF, 1'b0));
    send_cmd(build_cmd(K_RUN, 1'b0, 1'b1, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_POSITION, 1'b0, 1'b0, 24'd0, 32'd5, 1'b0));
    send_cmd(build_cmd(K_PULSE, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_RUN, 1'b1, 1'b1, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_DIR, 1'b0, 1'b1, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_PULSE, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_PHOTO, 1'b0, 1'b0, 24'd0, 32'd0, 1'b1));
    send_cmd(build_cmd(K_RUN, 1'b0, 1'b1, 24'd0, 32'd0, 1'b1));
    send_cmd(build_cmd(K_DIR, 1'b0, 1'b0, 24'd0, 32'd0, 1'b1));
    send_cmd(build_cmd(K_RUN, 1'b0, 1'b1, 24'd0, 32'd0, 1'b1));
    send_cmd(build_cmd(K_PHOTO, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_STOP_ALL, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_ESCAPE, 1'b1, 1'b1, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_ESCAPE, 1'b1, 1'b1, 24'd0, 32'd0, 1'b1));
    send_cmd(build_cmd(K_MOVE, 1'b1, 1'b0, 24'hFFFFFF, 32'd0, 1'b1));
    send_cmd(build_cmd(K_MOVE, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_MOVE, 1'b0, 1'b1, 24'd1, 32'd0, 1'b0));
    send_cmd(build_cmd(K_HOLD, 1'b1, 1'b1, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_RUN, 1'b1, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_POSITION, 1'b1, 1'b0, 24'd0, 32'h8000_0000, 1'b0));
    send_cmd(build_cmd(K_MOVE, 1'b1, 1'b1, 24'd1, 32'd0, 1'b0));
    send_cmd(build_cmd(K_PULSE, 1'b1, 1'b0, 24'd0, 32'd0, 1'b0));
    send_cmd(build_cmd(K_HOLD, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
  endtask

  task automatic test_travel_limits();
    write_limit(CFG_X_LIMIT, 24'd1);
    send_cmd(build_cmd(K_MOVE, 1'b0, 1'b0, 24'd2, 32'd0, 1'b0));
    send_cmd(build_cmd(K_MOVE, 1'b0, 1'b0, 24'd1, 32'd0, 1'b0));
    send_cmd(build_cmd(K_PULSE, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
    write_limit(CFG_Z_LIMIT, 24'd1);
    send_cmd(build_cmd(K_MOVE, 1'b1, 1'b1, 24'd2, 32'd0, 1'b0));
    send_cmd(build_cmd(K_MOVE, 1'b1, 1'b1, 24'd1, 32'd0, 1'b0));
    send_cmd(build_cmd(K_PULSE, 1'b1, 1'b0, 24'd0, 32'd0, 1'b0));
    write_limit(CFG_X_LIMIT, LIMIT_RESET);
    write_limit(CFG_Z_LIMIT, 24'hFFFFFE);
    send_cmd(build_cmd(K_MOVE, 1'b1, 1'b0, 24'hFFFFFF, 32'd0, 1'b0));
    send_cmd(build_cmd(K_MOVE, 1'b0, 1'b0, 24'hFFFFFF, 32'd0, 1'b0));
    send_cmd(build_cmd(K_STOP_ALL, 1'b0, 1'b0, 24'd0, 32'd0, 1'b0));
  endtask

  task automatic test_random_traffic(logic [23:0] x_lim, logic [23:0] z_lim, int unsigned n);
    write_limit(CFG_X_LIMIT, x_lim);
    write_limit(CFG_Z_LIMIT, z_lim);
    repeat (n) send_cmd(random_cmd());
  endtask

  task automatic test_backpressure();
    drain();
    no_gaps       = 1'b1;
    hold_off_left = 400;
    repeat (60) send_cmd(random_cmd());
    no_gaps = 1'b0;
  endtask

  // The receiver switches between stall patterns; a hold-off request wins.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_off_left != 0) begin
          hold_off_left--;
          out_stall_i <= 1'b1;
        end else begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 9) < 6);
            default: out_stall_i <= ~out_stall_i;
          endcase
        end
      end
    end
  end

  function automatic string show(smi_out_t o);
    return $sformatf("st=%0d run=%b%b dir=%b%b hold=%b%b pos=%0d rem=%0d done=%0d act=%b own=%b",
                     o.status, o.run_x, o.run_z, o.dir_x, o.dir_z, o.hold_x, o.hold_z,
                     o.position_out, o.remaining_out, o.completed_out, o.move_active_out,
                     o.limit_owned);
  endfunction

  task automatic report(string why, smi_out_t want, smi_out_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("result %0d: %s", checked_cnt, why);
      $display("  expected %s", show(want));
      $display("  actual   %s", show(got));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    smi_out_t want;
    string    bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_cnt++;
      if (expected_q.size() == 0) begin
        report("transfer with no command outstanding", '0, out_data_o);
      end else begin
        want = expected_q.pop_front();
        bad = "";
        if (out_data_o.status !== want.status) bad = {bad, " status"};
        if (out_data_o.run_x !== want.run_x) bad = {bad, " run_x"};
        if (out_data_o.run_z !== want.run_z) bad = {bad, " run_z"};
        if (out_data_o.dir_x !== want.dir_x) bad = {bad, " dir_x"};
        if (out_data_o.dir_z !== want.dir_z) bad = {bad, " dir_z"};
        if (out_data_o.hold_x !== want.hold_x) bad = {bad, " hold_x"};
        if (out_data_o.hold_z !== want.hold_z) bad = {bad, " hold_z"};
        if (out_data_o.position_out !== want.position_out) bad = {bad, " position_out"};
        if (out_data_o.remaining_out !== want.remaining_out) bad = {bad, " remaining_out"};
        if (out_data_o.completed_out !== want.completed_out) bad = {bad, " completed_out"};
        if (out_data_o.move_active_out !== want.move_active_out) bad = {bad, " move_active"};
        if (out_data_o.limit_owned !== want.limit_owned) bad = {bad, " limit_owned"};
        if (bad != "") report({"mismatch in", bad}, want, out_data_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    static int unsigned idle_cycles = 0;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : sequencer
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_travel_limits();
    test_random_traffic(LIMIT_RESET, LIMIT_RESET, 250);
    test_random_traffic(24'd1, LIMIT_RESET, 250);
    test_backpressure();
    test_random_traffic(LIMIT_RESET, 24'd1, 250);
    test_random_traffic(24'($urandom_range(2, 12)), 24'($urandom_range(2, 12)), 250);
    drain();
    repeat (4) @(posedge clk_i);
    if (expected_q.size() != 0) mismatch_cnt++;
    $display("Covered %0d commands and %0d results over %0d limit writes.",
             sent_cnt, checked_cnt, cfg_writes);
    $display("Interlock refused %0d starts; %0d counted moves ran to completion.",
             busy_cnt, moves_done);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
